>>> hw/rtl/lpno_pkg.sv
// Package: shared types and constants for the lidar nearest-obstacle detector.
`timescale 1ns / 1ps
package lpno_pkg;

    localparam int unsigned DistW   = 14;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned PosW    = 6;
    localparam int unsigned CfgIdxW = 8;

    localparam logic [ByteW-1:0] HeaderByte = 8'h54;
    localparam logic [PosW-1:0]  PosHunt    = 6'd0;
    localparam logic [PosW-1:0]  PosFirst   = 6'd1;
    localparam logic [PosW-1:0]  PointFirst = 6'd6;
    localparam logic [PosW-1:0]  PointLast  = 6'd41;
    localparam logic [PosW-1:0]  PosLast    = 6'd46;

    // Register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] RegEmergency = 8'd0;
    localparam logic [CfgIdxW-1:0] RegSafe      = 8'd1;
    localparam logic [CfgIdxW-1:0] RegValidLow  = 8'd2;
    localparam logic [CfgIdxW-1:0] RegValidHigh = 8'd3;

    localparam logic [DistW-1:0] EmergencyReset = 14'd120;
    localparam logic [DistW-1:0] SafeReset      = 14'd300;
    localparam logic [DistW-1:0] ValidLowReset  = 14'd10;
    localparam logic [DistW-1:0] ValidHighReset = 14'd12000;

    // Point byte phase within a 3-byte point
    typedef enum logic [1:0] {
        PH_LOW  = 2'd0,
        PH_HIGH = 2'd1,
        PH_INT  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [DistW-1:0] emergency_mm;
        logic [DistW-1:0] safe_mm;
        logic [DistW-1:0] valid_low_mm;
        logic [DistW-1:0] valid_high_mm;
    } t_cfg;

    typedef struct packed {
        logic [DistW-1:0] nearest_mm;
        logic             emergency_flag;
        logic             obstacle_near;
    } t_result;

    typedef struct packed {
        logic at_last;
    } t_trk_status;

endpackage

>>> hw/rtl/lidar_packet_nearest_obstacle_top.sv
// Top level: lidar packet nearest-obstacle detector with configuration registers.
`timescale 1ns / 1ps
// One received byte is taken per cycle, with no gap needed between bytes. Each byte
// passes through combinational logic into the packet tracker registers; the 47th
// byte of a packet loads the output register, and o_valid rises in the next cycle.
// Input stalls only when that last byte arrives while the previous result is still
// pending. Configuration writes are taken every cycle and apply from the next byte.
module lidar_packet_nearest_obstacle_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [lpno_pkg::ByteW-1:0]   i_rx_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lpno_pkg::DistW-1:0]   o_nearest_mm,
    output logic                         o_emergency_flag,
    output logic                         o_obstacle_near,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lpno_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [lpno_pkg::DistW-1:0]   i_cfg_data
);
    import lpno_pkg::*;

    t_cfg        r_cfg;
    t_trk_status w_status;
    t_result     w_res, w_out;
    logic        w_res_valid, w_blocked, w_accept;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes drop the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.emergency_mm  <= EmergencyReset;
            r_cfg.safe_mm       <= SafeReset;
            r_cfg.valid_low_mm  <= ValidLowReset;
            r_cfg.valid_high_mm <= ValidHighReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegEmergency: r_cfg.emergency_mm  <= i_cfg_data;
                RegSafe:      r_cfg.safe_mm       <= i_cfg_data;
                RegValidLow:  r_cfg.valid_low_mm  <= i_cfg_data;
                RegValidHigh: r_cfg.valid_high_mm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stall only a byte that would produce a result into a full output
    assign o_ready  = !(w_blocked && w_status.at_last);
    assign w_accept = i_valid && o_ready;

    lpno_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (r_cfg),
        .o_status    (w_status),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    lpno_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_ready     (i_ready),
        .o_blocked   (w_blocked),
        .o_valid     (o_valid),
        .o_res       (w_out)
    );

    assign o_nearest_mm     = w_out.nearest_mm;
    assign o_emergency_flag = w_out.emergency_flag;
    assign o_obstacle_near  = w_out.obstacle_near;

    a_flag_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && r_cfg.emergency_mm <= r_cfg.safe_mm && w_res.emergency_flag)
            |-> w_res.obstacle_near)
        else $error("emergency without obstacle under ordered thresholds");
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_accept && w_status.at_last))
        else $error("result without a packet end");
    a_stall_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && w_status.at_last))
        else $error("input stalled without cause");

endmodule

>>> hw/rtl/lpno_track.sv
// Packet tracker: header hunt, byte position, distance assembly and running minimum.
`timescale 1ns / 1ps
module lpno_track (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [lpno_pkg::ByteW-1:0] i_rx_byte,
    input  lpno_pkg::t_cfg             i_cfg,
    output lpno_pkg::t_trk_status      o_status,
    output logic                       o_res_valid,
    output lpno_pkg::t_result          o_res
);
    import lpno_pkg::*;

    logic [PosW-1:0]  r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic [ByteW-1:0] r_low, n_low;
    logic [DistW-1:0] r_min, n_min;
    logic [15:0]      w_dist;
    logic             w_take;

    assign w_dist = {i_rx_byte, r_low};
    assign w_take = (w_dist > {2'b00, i_cfg.valid_low_mm})
                 && (w_dist < {2'b00, i_cfg.valid_high_mm})
                 && (w_dist < {2'b00, r_min});

    // Advance position, latch low byte, update minimum
    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_low   = r_low;
        n_min   = r_min;
        if (i_accept) begin
            if (r_pos == PosHunt) begin
                if (i_rx_byte == HeaderByte) begin
                    n_pos   = PosFirst;
                    n_phase = PH_LOW;
                    n_min   = i_cfg.valid_high_mm;
                end
            end else begin
                if (r_pos >= PointFirst && r_pos <= PointLast) begin
                    unique case (r_phase)
                        PH_LOW: begin
                            n_low   = i_rx_byte;
                            n_phase = PH_HIGH;
                        end
                        PH_HIGH: begin
                            if (w_take) begin
                                n_min = w_dist[DistW-1:0];
                            end
                            n_phase = PH_INT;
                        end
                        PH_INT: begin
                            n_phase = PH_LOW;
                        end
                        default: begin
                            n_phase = PH_LOW;
                        end
                    endcase
                end
                n_pos = (r_pos == PosLast) ? PosHunt : r_pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= PosHunt;
            r_phase <= PH_LOW;
            r_low   <= '0;
            r_min   <= ValidHighReset;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_low   <= n_low;
            r_min   <= n_min;
        end
    end

    // The last packet byte carries no distance, so the result is the held minimum
    assign o_status.at_last  = (r_pos == PosLast);
    assign o_res_valid       = i_accept && (r_pos == PosLast);
    assign o_res.nearest_mm     = r_min;
    assign o_res.emergency_flag = (r_min < i_cfg.emergency_mm);
    assign o_res.obstacle_near  = (r_min < i_cfg.safe_mm);

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosLast)
        else $error("byte position past packet end");
    a_phase_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == PointFirst) |-> (r_phase == PH_LOW))
        else $error("point phase misaligned at first point byte");
    a_hunt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_pos == PosHunt && i_rx_byte != HeaderByte) |=> (r_pos == PosHunt))
        else $error("left hunt without header");
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == PosHunt))
        else $error("no return to hunt after result");

endmodule

>>> hw/rtl/lpno_out.sv
// Output register: holds one result request until the consumer takes it.
`timescale 1ns / 1ps
module lpno_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  lpno_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_blocked,
    output logic              o_valid,
    output lpno_pkg::t_result o_res
);
    import lpno_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Full and not drained this cycle: a new result cannot enter
    assign o_blocked = r_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload only when a new result arrives
    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !o_blocked)
        else $error("result overwrote a pending request");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready && !i_res_valid) |=> (r_valid && $stable(r_res)))
        else $error("pending result lost");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |=> (r_valid && r_res == $past(i_res)))
        else $error("result not captured");

endmodule
